@@ rtl/rsa_pkg.sv @@
// shared constants for the reference-counted slot allocator
// field widths, command and status codes, table size; no dependencies
package rsa_pkg;

	// table size and derived widths
	localparam int NUM_SLOTS   = 16;
	localparam int IDX_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int SLOT_W      = 4;
	localparam int SLOT_LIMIT  = 1 << SLOT_W;
	localparam int ALLOC_SLOTS = (NUM_SLOTS < SLOT_LIMIT) ? NUM_SLOTS : SLOT_LIMIT;

	// item fields
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 2;
	localparam int CNT_W    = 5;
	localparam logic [CNT_W-1:0] MAX_REFS = CNT_W'(16);

	// stream widths, padded to whole bytes
	localparam int S_DATA_W = 8;
	localparam int M_DATA_W = 16;

	// command codes
	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SHARE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ERR  = 2'd2;

endpackage

@@ rtl/rsa_ram.sv @@
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module rsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/refcounted_slot_allocator.sv @@
// top level of the reference-counted slot allocator
// depends on rsa_pkg and rsa_ram
//
// usage:
//   s_* channel takes one request item: cmd (allocate, share, free) and slot.
//   m_* channel returns one result item per request: status, granted_slot,
//   released and new_count.
//   allocate picks the lowest free slot and starts its count at one; share adds
//   one to a used slot's count (saturating at 16); free takes one away and
//   releases the slot when the count reaches zero.
// timing:
//   each item is read and then modified: the read fetches the slot's count from
//   the count ram, the modify step writes it back and loads the output register.
//   the count ram's registered read, with s_tready low during the modify step,
//   means the block takes no new item until the current one is finished.
// reset:
//   arst_n clears every used mark, so all slots are free; counts of free slots
//   are never used, so the count ram needs no clearing pass.
// back-pressure:
//   a finished result sits in the output register until m_tready; meanwhile
//   the next item is accepted and read, and waits there until the register
//   drains, with s_tready low.
module refcounted_slot_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [rsa_pkg::S_DATA_W-1:0]  s_tdata,   // cmd[1:0], slot[5:2], zero pad
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [rsa_pkg::M_DATA_W-1:0]  m_tdata    // status[1:0], granted_slot[5:2],
	                                                 // released[6], new_count[11:7], zero pad
);
	import rsa_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t                state_q;
	logic [CMD_W-1:0]      cmd_s1;
	logic [SLOT_W-1:0]     slot_s1;
	logic [NUM_SLOTS-1:0]  in_use_q;
	logic                  m_tvalid_q;
	logic [M_DATA_W-1:0]   m_tdata_q;

	// request fields
	logic [CMD_W-1:0]  in_cmd;
	logic [SLOT_W-1:0] in_slot;
	logic              accept;

	// count ram
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [CNT_W-1:0]  ram_wdata;
	logic [CNT_W-1:0]  ram_rdata;

	// execute stage
	logic                 done;
	logic [IDX_W-1:0]     cur_idx;
	logic                 slot_used;
	logic                 free_found;
	logic [IDX_W-1:0]     free_idx;
	logic [CNT_W-1:0]     dec_count;
	logic [STATUS_W-1:0]  res_status;
	logic [SLOT_W-1:0]    res_slot;
	logic                 res_released;
	logic [CNT_W-1:0]     res_count;
	logic                 set_used;
	logic                 clr_used;

	assign in_cmd   = s_tdata[CMD_W-1:0];
	assign in_slot  = s_tdata[CMD_W+SLOT_W-1:CMD_W];
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign done     = (state_q == S_EXEC) && (!m_tvalid_q || m_tready);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// reference counts, read on accept, written back when the item finishes
	rsa_ram #(
		.WIDTH(CNT_W),
		.DEPTH(NUM_SLOTS)
	) u_count_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(IDX_W'(in_slot)),
		.rdata(ram_rdata)
	);

	// lowest free slot among those the slot field can name
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = ALLOC_SLOTS - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	assign cur_idx   = IDX_W'(slot_s1);
	assign slot_used = (32'(slot_s1) < NUM_SLOTS) && in_use_q[cur_idx];
	assign dec_count = (ram_rdata != '0) ? ram_rdata - CNT_W'(1) : '0;

	// modify step: result fields and the write-back
	always_comb begin
		res_status   = ST_ERR;
		res_slot     = slot_s1;
		res_released = 1'b0;
		res_count    = '0;
		ram_we       = 1'b0;
		ram_waddr    = cur_idx;
		ram_wdata    = '0;
		set_used     = 1'b0;
		clr_used     = 1'b0;
		case (cmd_s1)
			CMD_ALLOC: begin
				if (free_found) begin
					res_status = ST_OK;
					res_slot   = SLOT_W'(free_idx);
					res_count  = CNT_W'(1);
					ram_we     = 1'b1;
					ram_waddr  = free_idx;
					ram_wdata  = CNT_W'(1);
					set_used   = 1'b1;
				end else begin
					res_status = ST_FULL;
					res_slot   = '0;
				end
			end
			CMD_SHARE: begin
				if (slot_used) begin
					if (ram_rdata >= MAX_REFS) begin
						// saturated: count unchanged, reported as is
						res_count = ram_rdata;
					end else begin
						res_status = ST_OK;
						res_count  = ram_rdata + CNT_W'(1);
						ram_we     = 1'b1;
						ram_wdata  = ram_rdata + CNT_W'(1);
					end
				end
			end
			CMD_FREE: begin
				if (slot_used) begin
					res_status = ST_OK;
					ram_we     = 1'b1;
					ram_wdata  = dec_count;
					if (dec_count == '0) begin
						res_released = 1'b1;
						clr_used     = 1'b1;
					end else begin
						res_count = dec_count;
					end
				end
			end
			default: begin
				// undefined command is ignored
			end
		endcase
		if (!done) begin
			ram_we   = 1'b0;
			set_used = 1'b0;
			clr_used = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_use_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// a new result replaces the one leaving in the same cycle
			if (done) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (done) begin
						state_q <= S_IDLE;
						if (set_used) begin
							in_use_q[ram_waddr] <= 1'b1;
						end
						if (clr_used) begin
							in_use_q[ram_waddr] <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= in_cmd;
			slot_s1 <= in_slot;
		end
		if (done) begin
			m_tdata_q <= M_DATA_W'({res_count, res_released, res_slot, res_status});
		end
	end

endmodule

@@ tb/tb_top.sv @@
// testbench for the reference-counted slot allocator: directed and random request items
// checked against a cycle-free mirror of the slot table; depends on rsa_pkg and the rtl top
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rsa_pkg::*;

	// the only command code the package leaves unnamed
	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
	// cycles with no item moving on either side before the run is given up
	localparam int STALL_LIMIT = 2000;
	// settle time after the last result
	localparam int DRAIN_CYCLES = 10;
	// length of the long receiver hold-off
	localparam int HOLD_CYCLES = 300;

	// one expected result item
	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   granted_slot;
		logic                released;
		logic [CNT_W-1:0]    new_count;
	} grant_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0;   // cmd[1:0], slot[5:2], zero pad
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;         // status[1:0], granted_slot[5:2], released[6],
	                                      // new_count[11:7], zero pad

	refcounted_slot_allocator u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// mirror of the slot table, updated when a request item is accepted
	logic             slot_used [NUM_SLOTS];
	logic [CNT_W-1:0] slot_refs [NUM_SLOTS];

	// results owed by the block, oldest first
	grant_t grants_due [$];

	int err_cnt      = 0;
	int snd_idle_pct = 7;
	int rcv_idle_pct = 68;
	int hold_left    = 0;
	int quiet_cycles = 0;

	// apply one request to the mirror and return the result it must produce
	function automatic grant_t predict_grant(input logic [CMD_W-1:0] cmd,
			input logic [SLOT_W-1:0] slot);
		grant_t g;
		logic   found;
		g     = '{ST_ERR, slot, 1'b0, '0};
		found = 1'b0;
		if (cmd == CMD_ALLOC) begin
			// lowest free slot wins; table full reports the full status, other fields zero
			g = '{ST_FULL, '0, 1'b0, '0};
			for (int i = 0; i < ALLOC_SLOTS; i++) begin
				if (!found && !slot_used[i]) begin
					found        = 1'b1;
					slot_used[i] = 1'b1;
					slot_refs[i] = CNT_W'(1);
					g            = '{ST_OK, SLOT_W'(i), 1'b0, CNT_W'(1)};
				end
			end
		end else if (cmd == CMD_NONE || int'(slot) >= NUM_SLOTS || !slot_used[slot]) begin
			// meaningless command or slot not in use: error, echo slot, table untouched
			g = '{ST_ERR, slot, 1'b0, '0};
		end else if (cmd == CMD_SHARE) begin
			if (slot_refs[slot] >= MAX_REFS) begin
				// saturated count stays and is reported
				g = '{ST_ERR, slot, 1'b0, slot_refs[slot]};
			end else begin
				slot_refs[slot] = slot_refs[slot] + 1'b1;
				g = '{ST_OK, slot, 1'b0, slot_refs[slot]};
			end
		end else begin
			// free: release when the count drops to zero
			if (slot_refs[slot] > 0)
				slot_refs[slot] = slot_refs[slot] - 1'b1;
			if (slot_refs[slot] == 0) begin
				slot_used[slot] = 1'b0;
				g = '{ST_OK, slot, 1'b1, '0};
			end else begin
				g = '{ST_OK, slot, 1'b0, slot_refs[slot]};
			end
		end
		return g;
	endfunction

	// random slot currently in use, or -1 when the table is empty
	function automatic int pick_used_slot();
		int used_idx [$];
		for (int i = 0; i < NUM_SLOTS; i++)
			if (slot_used[i])
				used_idx.push_back(i);
		if (used_idx.size() == 0)
			return -1;
		return used_idx[$urandom_range(0, used_idx.size() - 1)];
	endfunction

	// offer one request item, with random idle cycles first; returns right after the
	// accepting edge with valid still high, so back-to-back items need no gap
	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= S_DATA_W'({slot, cmd});
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		grants_due.push_back(predict_grant(cmd, slot));
	endtask

	// sender pause until every owed result has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (grants_due.size() != 0)
			@(posedge clk);
	endtask

	// one well-formed request with weights, or noise in one item of ten
	task automatic send_random_item(input int w_alloc, input int w_share, input int w_free);
		int pick;
		int s;
		pick = $urandom_range(0, 99);
		s    = pick_used_slot();
		if (pick < 10) begin
			send_item(CMD_W'($urandom_range(0, 3)), SLOT_W'($urandom_range(0, 15)));
		end else begin
			pick = $urandom_range(0, w_alloc + w_share + w_free - 1);
			if (s < 0 || pick < w_alloc)
				send_item(CMD_ALLOC, SLOT_W'($urandom_range(0, 15)));
			else if (pick < w_alloc + w_share)
				send_item(CMD_SHARE, SLOT_W'(s));
			else
				send_item(CMD_FREE, SLOT_W'(s));
		end
	endtask

	// extremes of the fields and each corner on a nearly empty table
	task automatic test_directed();
		send_item(CMD_SHARE, 4'd0);      // share on a free slot
		send_item(CMD_FREE, 4'd15);      // free on a free slot
		send_item(CMD_NONE, 4'd10);      // meaningless command
		send_item(CMD_ALLOC, 4'd15);     // slot field ignored, gets slot 0
		send_item(CMD_ALLOC, 4'd0);      // gets slot 1
		send_item(CMD_SHARE, 4'd1);      // count 2
		send_item(CMD_FREE, 4'd1);       // count 1
		send_item(CMD_FREE, 4'd1);       // released
		send_item(CMD_FREE, 4'd1);       // already released
		send_item(CMD_ALLOC, 4'd5);      // reuses slot 1
		send_item(CMD_NONE, 4'd1);       // ignored, count of slot 1 untouched
		send_item(CMD_SHARE, 4'd15);     // top index, not in use
		send_item(CMD_FREE, 4'd0);       // released
		send_item(CMD_FREE, 4'd1);       // released
	endtask

	// fill the whole table, hit the full report, then empty it again
	task automatic test_fill();
		int s;
		repeat (ALLOC_SLOTS + 1)
			send_item(CMD_ALLOC, SLOT_W'($urandom_range(0, 15)));
		send_item(CMD_ALLOC, 4'd0);
		s = pick_used_slot();
		if (s >= 0)
			send_item(CMD_SHARE, SLOT_W'(s));
		for (int i = 0; i < NUM_SLOTS; i++)
			while (slot_used[i])
				send_item(CMD_FREE, SLOT_W'(i));
	endtask

	// drive one slot's count up to saturation, past it, and back down to release
	task automatic test_saturation();
		int s;
		send_item(CMD_ALLOC, 4'd0);
		s = pick_used_slot();
		if (s >= 0) begin
			while (slot_refs[s] < MAX_REFS)
				send_item(CMD_SHARE, SLOT_W'(s));
			send_item(CMD_SHARE, SLOT_W'(s));
			send_item(CMD_SHARE, SLOT_W'(s));
			while (slot_used[s])
				send_item(CMD_FREE, SLOT_W'(s));
		end
	endtask

	task automatic test_random(input int n_items, input int w_alloc, input int w_share,
			input int w_free);
		repeat (n_items)
			send_random_item(w_alloc, w_share, w_free);
	endtask

	// receiver holds off while the sender keeps offering, so the block fills and
	// stalls its input; afterwards the sender waits for every result
	task automatic test_backpressure();
		int saved_pct;
		saved_pct    = snd_idle_pct;
		snd_idle_pct = 0;
		hold_left    = HOLD_CYCLES;
		repeat (20)
			send_random_item(40, 30, 30);
		snd_idle_pct = saved_pct;
		wait_drained();
	endtask

	// compare one result item with the oldest expectation
	function automatic void check_grant(input logic [M_DATA_W-1:0] d);
		grant_t g;
		if (grants_due.size() == 0) begin
			$error("result item with no request pending, tdata %h", d);
			err_cnt++;
			return;
		end
		g = grants_due.pop_front();
		if (d[1:0] !== g.status) begin
			$error("status: expected %0d, actual %0d", g.status, d[1:0]);
			err_cnt++;
		end
		if (d[5:2] !== g.granted_slot) begin
			$error("granted_slot: expected %0d, actual %0d", g.granted_slot, d[5:2]);
			err_cnt++;
		end
		if (d[6] !== g.released) begin
			$error("released: expected %0d, actual %0d", g.released, d[6]);
			err_cnt++;
		end
		if (d[11:7] !== g.new_count) begin
			$error("new_count: expected %0d, actual %0d", g.new_count, d[11:7]);
			err_cnt++;
		end
	endfunction

	// result side: check accepted items, then pick the next ready value
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				check_grant(m_tdata);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
			end
		end
	end

	// watchdog: give up when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			slot_used[i] = 1'b0;
			slot_refs[i] = '0;
		end
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles rarely, receiver often
		snd_idle_pct = 7;
		rcv_idle_pct = 68;
		test_directed();
		test_fill();
		test_saturation();
		test_random(170, 40, 30, 30);

		// the other way round, with an alloc-heavy mix that keeps the table full
		snd_idle_pct = 68;
		rcv_idle_pct = 7;
		test_backpressure();
		test_random(170, 60, 20, 20);

		// no idling at all, share-heavy so counts climb
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		test_random(170, 25, 50, 25);
		test_saturation();

		s_tvalid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (err_cnt == 0 && grants_due.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

@@ refcounted_slot_allocator.f @@
rtl/rsa_pkg.sv
rtl/rsa_ram.sv
rtl/refcounted_slot_allocator.sv
tb/tb_top.sv
